/* sv/bfc_pkg.sv */
`default_nettype none

package bfc_pkg;

    localparam int BFC_STRING_POSITIONS = 65536;
    localparam int BFC_QUEUE_DEPTH      = 4;
    localparam int BFC_MAX_RESULTS      = 4;
    localparam int BFC_CNT_W            = $clog2(BFC_MAX_RESULTS + 1);
    localparam int BFC_SEL_W            = $clog2(BFC_MAX_RESULTS);

    localparam logic [7:0] CHAR_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        DIAG_OPEN   = 3'd0,
        DIAG_CLOSE  = 3'd1,
        DIAG_PARSE  = 3'd2,
        DIAG_BOUNDS = 3'd3,
        DIAG_DONE   = 3'd4
    } diag_t;

    typedef enum logic [1:0] {
        BR_NONE  = 2'd0,
        BR_OPEN  = 2'd1,
        BR_CLOSE = 2'd2
    } brace_t;

    typedef struct packed {
        diag_t       code;
        logic [15:0] position;
    } result_t;

    typedef struct packed {
        logic [BFC_CNT_W-1:0]            count;
        result_t [BFC_MAX_RESULTS-1:0]   res;
    } bundle_t;

endpackage

`default_nettype wire

/* sv/brace_format_string_checker_unit.sv */
// Brace format string checker.
// Input stream (s_): one byte of the format string per transaction in
// s_tdata[7:0]; s_tlast marks the final byte of the string.
// Output stream (m_): one diagnostic per transaction. m_tdata[2:0] is the
// code (unmatched open, unmatched close, unparsable index, index out of
// bounds, done), m_tdata[18:3] the byte offset, upper bits zero. m_tlast
// is high on the done diagnostic that ends each string.
// cfg_we/cfg_wdata load the argument count; write it only while idle.
// Throughput: one byte per cycle while the queue has room and one
// diagnostic per cycle while m_tready is high. A byte raises up to three
// diagnostics, drained one a cycle, so a burst of them can slow the input.
// With the queue empty and the output idle, a byte is parsed in the cycle
// it is taken and its bundle is written into the queue; the first
// diagnostic then loads the output register that drives m_tvalid.
// A bundle queue between the parser and the output serializer absorbs
// stalls; s_tready drops only when the queue is full.
// Reset clears the parse state, the queue and the argument count.
`default_nettype none

module brace_format_string_checker_unit
    import bfc_pkg::*;
#(
    parameter int STRING_POSITIONS = BFC_STRING_POSITIONS,
    parameter int QUEUE_DEPTH      = BFC_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] diag_code, [18:3] position
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata
);

    logic    q_full, q_push, q_pop, q_empty;
    bundle_t q_in, q_head;

    bfc_front #(
        .STRING_POSITIONS(STRING_POSITIONS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    bfc_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    bfc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* sv/bfc_front.sv */
`default_nettype none

module bfc_front
    import bfc_pkg::*;
#(
    parameter int STRING_POSITIONS = BFC_STRING_POSITIONS
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       q_full,
    output logic            q_push,
    output bundle_t         q_data
);

    localparam int PW = $clog2(STRING_POSITIONS);

    logic          accept;

    logic [7:0]    arg_count_reg;
    logic          field_open_reg,  field_open_next;
    logic [PW-1:0] open_pos_reg,    open_pos_next;
    brace_t        pend_reg,        pend_next;
    logic [PW-1:0] pend_pos_reg,    pend_pos_next;
    logic [PW-1:0] byte_pos_reg,    byte_pos_next;
    logic [15:0]   field_len_reg,   field_len_next;
    logic          colon_seen_reg,  colon_seen_next;
    logic          colon_first_reg, colon_first_next;
    logic          prefix_bad_reg,  prefix_bad_next;
    logic [63:0]   index_reg,       index_next;
    logic          overflow_reg,    overflow_next;

    logic [BFC_CNT_W-1:0]          n_res;
    result_t [BFC_MAX_RESULTS-1:0] res;

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
        return (p == PW'(STRING_POSITIONS - 1)) ? '0 : p + 1'b1;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        brace_t        kind;
        logic [67:0]   sum;
        logic [PW-1:0] at;
        brace_t        bk;
        logic [PW-1:0] bpos;

        field_open_next  = field_open_reg;
        open_pos_next    = open_pos_reg;
        pend_next        = pend_reg;
        pend_pos_next    = pend_pos_reg;
        field_len_next   = field_len_reg;
        colon_seen_next  = colon_seen_reg;
        colon_first_next = colon_first_reg;
        prefix_bad_next  = prefix_bad_reg;
        index_next       = index_reg;
        overflow_next    = overflow_reg;
        byte_pos_next    = pos_inc(byte_pos_reg);
        n_res            = '0;
        res              = '0;
        sum              = '0;
        at               = '0;
        bk               = BR_NONE;
        bpos             = '0;

        kind = (s_tdata == CHAR_OPEN)  ? BR_OPEN :
               (s_tdata == CHAR_CLOSE) ? BR_CLOSE : BR_NONE;

        if (pend_reg != BR_NONE && kind == pend_reg) begin
            // escaped pair: two plain bytes, never a digit or colon
            if (field_open_next) begin
                if (!colon_seen_next) begin
                    prefix_bad_next = 1'b1;
                end
                field_len_next = (field_len_next >= LEN_MAX - 16'd1) ? LEN_MAX
                                 : field_len_next + 16'd2;
            end
            pend_next = BR_NONE;
        end else begin
            if (pend_reg != BR_NONE) begin
                bk   = pend_reg;
                bpos = pend_pos_reg;
                if (bk == BR_OPEN) begin
                    if (field_open_next) begin
                        res[n_res[BFC_SEL_W-1:0]].code     = DIAG_OPEN;
                        res[n_res[BFC_SEL_W-1:0]].position = 16'(open_pos_next);
                        n_res = n_res + 1'b1;
                    end
                    field_open_next = 1'b1;
                    open_pos_next   = bpos;
                end else begin
                    if (!field_open_next) begin
                        res[n_res[BFC_SEL_W-1:0]].code     = DIAG_CLOSE;
                        res[n_res[BFC_SEL_W-1:0]].position = 16'(bpos);
                        n_res = n_res + 1'b1;
                    end else if (field_len_next != 16'd0) begin
                        at = pos_inc(open_pos_next);
                        if (colon_first_next || prefix_bad_next || overflow_next) begin
                            res[n_res[BFC_SEL_W-1:0]].code     = DIAG_PARSE;
                            res[n_res[BFC_SEL_W-1:0]].position = 16'(at);
                            n_res = n_res + 1'b1;
                        end else if (index_next >= {56'd0, arg_count_reg}) begin
                            res[n_res[BFC_SEL_W-1:0]].code     = DIAG_BOUNDS;
                            res[n_res[BFC_SEL_W-1:0]].position = 16'(at);
                            n_res = n_res + 1'b1;
                        end
                    end
                    field_open_next = 1'b0;
                end
                field_len_next   = '0;
                colon_seen_next  = 1'b0;
                colon_first_next = 1'b0;
                prefix_bad_next  = 1'b0;
                index_next       = '0;
                overflow_next    = 1'b0;
                pend_next        = BR_NONE;
            end
            if (kind != BR_NONE) begin
                pend_next     = kind;
                pend_pos_next = byte_pos_reg;
            end else if (field_open_next) begin
                if (!colon_seen_next) begin
                    if (s_tdata == CHAR_COLON) begin
                        colon_seen_next  = 1'b1;
                        colon_first_next = (field_len_next == 16'd0);
                    end else if (s_tdata >= CHAR_ZERO && s_tdata <= CHAR_NINE) begin
                        sum = {index_next, 3'b000} + {3'b000, index_next, 1'b0}
                              + {60'd0, s_tdata - CHAR_ZERO};
                        if (sum[67:64] != 4'd0) begin
                            overflow_next = 1'b1;
                        end else begin
                            index_next = sum[63:0];
                        end
                    end else begin
                        prefix_bad_next = 1'b1;
                    end
                end
                if (field_len_next != LEN_MAX) begin
                    field_len_next = field_len_next + 16'd1;
                end
            end
        end

        if (s_tlast) begin
            if (pend_next != BR_NONE) begin
                bk   = pend_next;
                bpos = pend_pos_next;
                if (bk == BR_OPEN) begin
                    if (field_open_next) begin
                        res[n_res[BFC_SEL_W-1:0]].code     = DIAG_OPEN;
                        res[n_res[BFC_SEL_W-1:0]].position = 16'(open_pos_next);
                        n_res = n_res + 1'b1;
                    end
                    field_open_next = 1'b1;
                    open_pos_next   = bpos;
                end else begin
                    if (!field_open_next) begin
                        res[n_res[BFC_SEL_W-1:0]].code     = DIAG_CLOSE;
                        res[n_res[BFC_SEL_W-1:0]].position = 16'(bpos);
                        n_res = n_res + 1'b1;
                    end else if (field_len_next != 16'd0) begin
                        at = pos_inc(open_pos_next);
                        if (colon_first_next || prefix_bad_next || overflow_next) begin
                            res[n_res[BFC_SEL_W-1:0]].code     = DIAG_PARSE;
                            res[n_res[BFC_SEL_W-1:0]].position = 16'(at);
                            n_res = n_res + 1'b1;
                        end else if (index_next >= {56'd0, arg_count_reg}) begin
                            res[n_res[BFC_SEL_W-1:0]].code     = DIAG_BOUNDS;
                            res[n_res[BFC_SEL_W-1:0]].position = 16'(at);
                            n_res = n_res + 1'b1;
                        end
                    end
                    field_open_next = 1'b0;
                end
            end
            if (field_open_next) begin
                res[n_res[BFC_SEL_W-1:0]].code     = DIAG_OPEN;
                res[n_res[BFC_SEL_W-1:0]].position = 16'(open_pos_next);
                n_res = n_res + 1'b1;
            end
            res[n_res[BFC_SEL_W-1:0]].code     = DIAG_DONE;
            res[n_res[BFC_SEL_W-1:0]].position = 16'd0;
            n_res = n_res + 1'b1;

            field_open_next  = 1'b0;
            open_pos_next    = '0;
            pend_next        = BR_NONE;
            pend_pos_next    = '0;
            byte_pos_next    = '0;
            field_len_next   = '0;
            colon_seen_next  = 1'b0;
            colon_first_next = 1'b0;
            prefix_bad_next  = 1'b0;
            index_next       = '0;
            overflow_next    = 1'b0;
        end
    end

    assign q_push       = accept && (n_res != '0);
    assign q_data.count = n_res;
    assign q_data.res   = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arg_count_reg <= '0;
        end else if (cfg_we) begin
            arg_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_open_reg  <= 1'b0;
            open_pos_reg    <= '0;
            pend_reg        <= BR_NONE;
            pend_pos_reg    <= '0;
            byte_pos_reg    <= '0;
            field_len_reg   <= '0;
            colon_seen_reg  <= 1'b0;
            colon_first_reg <= 1'b0;
            prefix_bad_reg  <= 1'b0;
            index_reg       <= '0;
            overflow_reg    <= 1'b0;
        end else if (accept) begin
            field_open_reg  <= field_open_next;
            open_pos_reg    <= open_pos_next;
            pend_reg        <= pend_next;
            pend_pos_reg    <= pend_pos_next;
            byte_pos_reg    <= byte_pos_next;
            field_len_reg   <= field_len_next;
            colon_seen_reg  <= colon_seen_next;
            colon_first_reg <= colon_first_next;
            prefix_bad_reg  <= prefix_bad_next;
            index_reg       <= index_next;
            overflow_reg    <= overflow_next;
        end
    end

endmodule

`default_nettype wire

/* sv/bfc_queue.sv */
`default_nettype none

module bfc_queue
    import bfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = BFC_QUEUE_DEPTH
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire bundle_t push_data,
    output logic         full,
    input  wire logic    pop,
    output bundle_t      head,
    output logic         empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    bundle_t         slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/bfc_back.sv */
`default_nettype none

module bfc_back
    import bfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire bundle_t     head,
    input  wire logic        empty,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);

    logic [BFC_SEL_W-1:0] sel_reg, sel_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_res_reg;
    logic                 load;
    logic                 at_end;

    assign load   = !empty && (!out_valid_reg || m_tready);
    assign at_end = (BFC_CNT_W'(sel_reg) + 1'b1) == head.count;
    assign pop    = load && at_end;

    always_comb begin
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            sel_next       = at_end ? '0 : sel_reg + 1'b1;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_res_reg <= head.res[sel_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_res_reg.position, out_res_reg.code};
    assign m_tlast  = (out_res_reg.code == DIAG_DONE);

endmodule

`default_nettype wire

/* sv/bfc_checker.sv */
`default_nettype none

module bfc_checker
    import bfc_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_done_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[2:0] == DIAG_DONE && m_tdata[18:3] == 16'd0)
        else $error("done transaction malformed");

    a_last_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == DIAG_DONE |-> m_tlast)
        else $error("done transaction without tlast");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= DIAG_DONE && m_tdata[23:19] == 5'd0)
        else $error("diagnostic code or padding out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind brace_format_string_checker_unit bfc_checker u_bfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* sim/tb_brace_format_string_checker_unit.sv */
`timescale 1ns / 1ps

module tb_brace_format_string_checker_unit;
    import bfc_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        diag_t       code;
        logic [15:0] pos;
        logic        fin;
    } diag_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;

    logic [8:0]  byte_q[$];
    diag_rec_t   diag_expect[$];
    logic [7:0]  draft[$];

    int unsigned s_wait = 0;
    int unsigned m_wait = 0;
    bit          s_calm = 1'b0;
    bit          m_calm = 1'b0;
    int          failures = 0;
    int unsigned quiet_cycles = 0;
    int unsigned bytes_sent = 0;

    // checker state
    logic [7:0]  argc_model;
    bit          in_field;
    logic [15:0] field_start;
    brace_t      held;
    logic [15:0] held_at;
    logic [15:0] offset;
    logic [15:0] fld_len;
    bit          colon_hit;
    bit          colon_lead;
    bit          junk_prefix;
    logic [63:0] idx_acc;
    bit          idx_ovf;

    brace_format_string_checker_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    function void push_diag(diag_t code, logic [15:0] pos, logic fin);
        diag_rec_t r;
        r.code = code;
        r.pos  = pos;
        r.fin  = fin;
        diag_expect.push_back(r);
    endfunction

    function void clear_field_state();
        fld_len     = 16'd0;
        colon_hit   = 1'b0;
        colon_lead  = 1'b0;
        junk_prefix = 1'b0;
        idx_acc     = 64'd0;
        idx_ovf     = 1'b0;
    endfunction

    function void clear_string_state();
        in_field    = 1'b0;
        field_start = 16'd0;
        held        = BR_NONE;
        held_at     = 16'd0;
        offset      = 16'd0;
        clear_field_state();
    endfunction

    function void absorb_char(logic [7:0] c);
        logic [63:0] d;
        if (!in_field) return;
        if (!colon_hit) begin
            if (c == CHAR_COLON) begin
                colon_hit  = 1'b1;
                colon_lead = (fld_len == 16'd0);
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                d = 64'(c - CHAR_ZERO);
                if (idx_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) idx_ovf = 1'b1;
                else idx_acc = idx_acc * 64'd10 + d;
            end else begin
                junk_prefix = 1'b1;
            end
        end
        if (fld_len != LEN_MAX) fld_len = fld_len + 16'd1;
    endfunction

    function void resolve_brace(brace_t kind, logic [15:0] pos);
        if (kind == BR_OPEN) begin
            if (in_field) push_diag(DIAG_OPEN, field_start, 1'b0);
            in_field    = 1'b1;
            field_start = pos;
            clear_field_state();
        end else begin
            if (!in_field) begin
                push_diag(DIAG_CLOSE, pos, 1'b0);
            end else if (fld_len != 16'd0) begin
                if (colon_lead || junk_prefix || idx_ovf)
                    push_diag(DIAG_PARSE, field_start + 16'd1, 1'b0);
                else if (idx_acc >= {56'd0, argc_model})
                    push_diag(DIAG_BOUNDS, field_start + 16'd1, 1'b0);
            end
            in_field = 1'b0;
            clear_field_state();
        end
    endfunction

    function void predict_byte(logic [7:0] c, logic fin);
        brace_t      kind;
        logic [15:0] here;
        here = offset;
        kind = (c == CHAR_OPEN) ? BR_OPEN : (c == CHAR_CLOSE) ? BR_CLOSE : BR_NONE;
        if (held != BR_NONE && kind == held) begin
            absorb_char(c);
            absorb_char(c);
            held = BR_NONE;
        end else begin
            if (held != BR_NONE) begin
                resolve_brace(held, held_at);
                held = BR_NONE;
            end
            if (kind != BR_NONE) begin
                held    = kind;
                held_at = here;
            end else begin
                absorb_char(c);
            end
        end
        offset = here + 16'd1;
        if (fin) begin
            if (held != BR_NONE) begin
                resolve_brace(held, held_at);
                held = BR_NONE;
            end
            if (in_field) push_diag(DIAG_OPEN, field_start, 1'b0);
            push_diag(DIAG_DONE, 16'd0, 1'b1);
            clear_string_state();
        end
    endfunction

    // input driver
    always @(posedge aclk) begin
        logic [8:0] nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_wait   <= 0;
        end else begin
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (s_wait != 0) begin
                    s_tvalid <= 1'b0;
                    s_wait   <= s_wait - 1;
                end else if (byte_q.size() != 0) begin
                    nxt = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt[7:0];
                    s_tlast  <= nxt[8];
                    s_wait   <= s_calm ? 0 : $urandom_range(0, 11);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        diag_rec_t   r;
        int unsigned w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_wait   <= 0;
        end else if (m_tvalid && m_tready) begin
            if (diag_expect.size() == 0) begin
                $error("unexpected transaction: diag_code %0d position %0d",
                       m_tdata[2:0], m_tdata[18:3]);
                failures++;
            end else begin
                r = diag_expect.pop_front();
                if (m_tdata[2:0] !== r.code) begin
                    $error("diag_code: expected %0d, got %0d", r.code, m_tdata[2:0]);
                    failures++;
                end
                if (m_tdata[18:3] !== r.pos) begin
                    $error("position: expected %0d, got %0d", r.pos, m_tdata[18:3]);
                    failures++;
                end
                if (m_tlast !== r.fin) begin
                    $error("last_result: expected %0d, got %0d", r.fin, m_tlast);
                    failures++;
                end
            end
            w = m_calm ? 0 : $urandom_range(0, 11);
            m_wait   <= w;
            m_tready <= (w == 0);
        end else if (m_wait != 0) begin
            m_wait   <= m_wait - 1;
            m_tready <= (m_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic wait_drained();
        while (byte_q.size() != 0 || s_tvalid || diag_expect.size() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_arg_count(logic [7:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        argc_model = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic add_text(string t);
        foreach (t[i]) draft.push_back(t[i]);
    endtask

    task automatic add_plain(int n);
        logic [7:0] c;
        repeat (n) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CHAR_OPEN || c == CHAR_CLOSE);
            draft.push_back(c);
        end
    endtask

    task automatic add_digits(int n, int lo_first);
        draft.push_back(8'(CHAR_ZERO + $urandom_range(lo_first, 9)));
        repeat (n - 1) draft.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic add_escape();
        if ($urandom_range(0, 1) != 0) add_text("{{");
        else add_text("}}");
    endtask

    task automatic add_spec();
        draft.push_back(CHAR_COLON);
        add_plain($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) add_escape();
    endtask

    task automatic add_field();
        int unsigned kind;
        int          n;
        draft.push_back(CHAR_OPEN);
        kind = $urandom_range(0, 9);
        case (kind)
            0: ;
            1, 2: begin
                repeat ($urandom_range(0, 2)) draft.push_back(CHAR_ZERO);
                add_text($sformatf("%0d", $urandom_range(0, 300)));
            end
            3: begin
                n = int'(argc_model) + int'($urandom_range(0, 2)) - 1;
                if (n < 0) n = 0;
                add_text($sformatf("%0d", n));
            end
            4: add_text("18446744073709551615");
            5: begin
                if ($urandom_range(0, 1) != 0) add_text("18446744073709551616");
                else add_digits($urandom_range(20, 24), 2);
            end
            6: begin
                add_digits($urandom_range(1, 2), 0);
                if ($urandom_range(0, 1) != 0) add_escape();
                else add_plain(1);
                add_digits(1, 0);
            end
            7: begin
                draft.push_back(CHAR_COLON);
                add_plain($urandom_range(0, 3));
            end
            8: add_digits($urandom_range(1, 19), 0);
            default: add_plain($urandom_range(1, 4));
        endcase
        if (kind != 7 && $urandom_range(0, 2) == 0) add_spec();
        if ($urandom_range(0, 9) != 0) draft.push_back(CHAR_CLOSE);
    endtask

    task automatic queue_draft();
        foreach (draft[i]) byte_q.push_back({i == draft.size() - 1, draft[i]});
        bytes_sent += draft.size();
        draft.delete();
    endtask

    task automatic queue_str(string t);
        add_text(t);
        queue_draft();
    endtask

    task automatic compose_string();
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 9))
                0, 1: add_plain($urandom_range(1, 4));
                2: add_escape();
                8: draft.push_back($urandom_range(0, 1) != 0 ? CHAR_OPEN : CHAR_CLOSE);
                9: repeat ($urandom_range(1, 3)) draft.push_back(8'($urandom_range(0, 255)));
                default: add_field();
            endcase
        end
    endtask

    initial begin
        logic [7:0] settings[$];
        clear_string_state();
        argc_model = 8'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_arg_count(8'd3);
        queue_str("{}");
        queue_str("{{}}");
        queue_str("{0}{3}");
        queue_str("{:x}");
        queue_str("{1a}");
        queue_str("}");
        queue_str("x{");
        queue_str("{2{{}");
        wait_drained();

        settings = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'($urandom_range(0, 255))};
        foreach (settings[k]) begin
            write_arg_count(settings[k]);
            bytes_sent = 0;
            while (bytes_sent < 52) begin
                s_calm = ($urandom_range(0, 3) == 0);
                m_calm = ($urandom_range(0, 3) == 0);
                compose_string();
                queue_draft();
                while (byte_q.size() > 8) @(negedge aclk);
            end
            wait_drained();
        end

        if (failures == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
